FILE: rtl/afu_pkg.sv
package afu_pkg;

   localparam int DW      = 32;
   localparam int FRAC    = 24;
   localparam int SITES   = 16;
   localparam int SLICES  = 64;
   localparam int IDX_W   = $clog2(SITES);
   localparam int SLICE_W = $clog2(SLICES);
   localparam int ADDR_W  = 2 * IDX_W;
   localparam int CNT_W   = ADDR_W;
   localparam int KIND_W  = 3;
   localparam int XW      = 2 * DW + 2;
   localparam int SHRINK_W = 25;
   localparam int GROW_W   = 31;
   localparam int CSR_W    = 31;
   localparam int CSR_IDX_W = 1;
   localparam int DRAIN    = 3;

   typedef logic signed [DW-1:0]   data_type;
   typedef logic signed [2*DW-1:0] prod_type;
   typedef logic signed [XW-1:0]   wide_type;

   localparam logic [KIND_W-1:0] KIND_LOAD  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FLOAD = 3'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLIP  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROW   = 1'b1;

   localparam data_type DATA_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam wide_type X_MAX  = wide_type'(DATA_MAX);
   localparam wide_type X_MIN  = wide_type'(DATA_MIN);
   localparam wide_type ONE_X  = wide_type'(1) <<< FRAC;
   localparam wide_type HALF_X = wide_type'(1) <<< (FRAC - 1);

   typedef enum logic [2:0] {
      OP_NONE, OP_TERM, OP_COL, OP_ROW, OP_UPD, OP_RATIO, OP_READ
   } lane_op_type;

   typedef enum logic [1:0] {SEL_SPIN, SEL_BOTH, SEL_UP} sel_type;

   typedef enum logic [2:0] {
      ADDR_ENTRY, ADDR_DIAG, ADDR_COL, ADDR_ROW, ADDR_SWEEP
   } addr_src_type;

   typedef struct packed {
      lane_op_type        op;
      logic [ADDR_W-1:0]  addr;
      logic               wr;
      logic               div_start;
      logic               clear;
   } lane_cmd_type;

   typedef struct packed {
      logic               capture;
      logic               entry_wr;
      lane_op_type        op;
      sel_type            sel;
      addr_src_type       src;
      logic [CNT_W-1:0]   cnt;
      logic               fcap;
      logic               fwr;
      logic               flip;
      logic               div_start;
      logic               emit;
   } dp_cmd_type;

   typedef struct packed {
      logic               busy;
   } dp_status_type;

   function automatic data_type sat_fn(input wide_type x);
      if (x > X_MAX) return DATA_MAX;
      if (x < X_MIN) return DATA_MIN;
      return data_type'(x);
   endfunction

   function automatic logic ovf_fn(input wide_type x);
      return (x > X_MAX) || (x < X_MIN);
   endfunction

   function automatic wide_type rnd_fn(input prod_type p);
      wide_type y;
      y = wide_type'(p) + HALF_X;
      return y >>> FRAC;
   endfunction

endpackage

FILE: rtl/afu_req_if.sv
interface afu_req_if import afu_pkg::*;;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic               spin;
   logic [IDX_W-1:0]   row;
   logic [IDX_W-1:0]   column;
   logic [SLICE_W-1:0] slice;
   logic [IDX_W-1:0]   site;
   data_type           entry_value;
   logic               field_bit;

   modport source(output valid, kind, spin, row, column, slice, site, entry_value,
                  field_bit, input ready);
   modport sink(input valid, kind, spin, row, column, slice, site, entry_value,
                field_bit, output ready);
endinterface

FILE: rtl/afu_rsp_if.sv
interface afu_rsp_if import afu_pkg::*;;
   logic     valid;
   logic     ready;
   data_type result_value;
   logic     overflow;

   modport source(output valid, result_value, overflow, input ready);
   modport sink(input valid, result_value, overflow, output ready);
endinterface

FILE: rtl/afu_ram.sv
module afu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: rtl/afu_lane.sv
module afu_lane import afu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  lane_cmd_type     cmd,
   input  data_type         wr_data,
   input  data_type         delta,
   input  data_type         peer_term,
   input  logic [IDX_W-1:0] diag,
   output data_type         term,
   output data_type         res,
   output logic             ov,
   output logic             busy
);
   localparam int QW = DW - 1 + FRAC;
   localparam int DCNT_W = $clog2(QW + 1);
   localparam logic [QW-1:0] Q_LIM = QW'(1) << (DW - 1);

   logic [DW-1:0] rdata;
   data_type g_d;
   logic ram_we;
   logic [ADDR_W-1:0] waddr;
   data_type wdata;

   lane_op_type op_d_ff, op_m_ff, op_w_ff;
   logic [ADDR_W-1:0] addr_d_ff, addr_m_ff, addr_w_ff;
   data_type a_m_ff, b_m_ff, g_m_ff, g_w_ff;
   logic ova_m_ff, ova_w_ff;
   prod_type p_w_ff;
   data_type col_ff [SITES];
   data_type rowv_ff [SITES];
   data_type term_ff, res_ff, f_ff;
   logic ov_ff;

   logic [DW-1:0] rem_ff, dv_ff;
   logic [QW-1:0] quo_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic neg_ff, busy_ff;

   data_type a_in, b_in;
   logic ova_in;
   wide_type x_d, r_x, t_x, v_x, u_x;
   data_type r_w, t_w, v_w, u_w;
   logic ov_w;
   logic [DW:0] trial;
   logic ge;
   logic [DW-1:0] rem_next;
   logic [QW-1:0] q_next;
   logic [DW-1:0] d_abs, t_abs;

   afu_ram #(.WIDTH(DW), .DEPTH(SITES * SITES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (cmd.addr),
      .rdata (rdata)
   );

   assign g_d = rdata;

   always_comb begin
      a_in = g_d;
      b_in = g_d;
      ova_in = 1'b0;
      x_d = ONE_X - wide_type'(g_d);
      case (op_d_ff)
         OP_TERM: begin
            a_in = sat_fn(x_d);
            ova_in = ovf_fn(x_d);
            b_in = delta;
         end
         OP_COL: begin
            a_in = f_ff;
         end
         OP_UPD: begin
            a_in = col_ff[addr_d_ff[ADDR_W-1:IDX_W]];
            b_in = rowv_ff[addr_d_ff[IDX_W-1:0]];
         end
         OP_RATIO: begin
            a_in = term_ff;
            b_in = peer_term;
         end
         default: ;
      endcase
   end

   always_comb begin
      r_x = rnd_fn(p_w_ff);
      r_w = sat_fn(r_x);
      t_x = ONE_X + wide_type'(r_w);
      t_w = sat_fn(t_x);
      v_x = ((addr_w_ff[IDX_W-1:0] == diag) ? ONE_X : '0) - wide_type'(g_w_ff);
      v_w = sat_fn(v_x);
      u_x = wide_type'(g_w_ff) - wide_type'(r_w);
      u_w = sat_fn(u_x);
      case (op_w_ff)
         OP_TERM:  ov_w = ova_w_ff | ovf_fn(r_x) | ovf_fn(t_x);
         OP_COL:   ov_w = ovf_fn(r_x);
         OP_ROW:   ov_w = ovf_fn(v_x);
         OP_UPD:   ov_w = ovf_fn(r_x) | ovf_fn(u_x);
         OP_RATIO: ov_w = ovf_fn(r_x);
         default:  ov_w = 1'b0;
      endcase
   end

   assign ram_we = cmd.wr | (op_w_ff == OP_UPD);
   assign waddr  = cmd.wr ? cmd.addr : addr_w_ff;
   assign wdata  = cmd.wr ? wr_data : u_w;

   always_comb begin
      trial = {rem_ff, quo_ff[QW-1]};
      ge = trial >= {1'b0, dv_ff};
      rem_next = ge ? DW'(trial - {1'b0, dv_ff}) : trial[DW-1:0];
      q_next = {quo_ff[QW-2:0], ge};
      d_abs = delta[DW-1] ? DW'(-delta) : DW'(delta);
      t_abs = term_ff[DW-1] ? DW'(-term_ff) : DW'(term_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_d_ff <= OP_NONE;
         op_m_ff <= OP_NONE;
         op_w_ff <= OP_NONE;
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
         res_ff  <= '0;
      end else begin
         op_d_ff <= cmd.op;
         op_m_ff <= op_d_ff;
         op_w_ff <= op_m_ff;
         if (cmd.clear) begin
            ov_ff  <= 1'b0;
            res_ff <= '0;
         end else begin
            if (ov_w) begin
               ov_ff <= 1'b1;
            end
            if (op_w_ff == OP_RATIO) begin
               res_ff <= r_w;
            end else if (op_w_ff == OP_READ) begin
               res_ff <= g_w_ff;
            end
            if (cmd.div_start && term_ff == '0) begin
               ov_ff <= 1'b1;
            end
            if (busy_ff && dcnt_ff == DCNT_W'(1)) begin
               if (neg_ff ? (q_next > Q_LIM) : (q_next > Q_LIM - QW'(1))) begin
                  ov_ff <= 1'b1;
               end
            end
         end
         if (cmd.div_start) begin
            busy_ff <= (term_ff != '0);
         end else if (busy_ff && dcnt_ff == DCNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_d_ff <= cmd.addr;
      addr_m_ff <= addr_d_ff;
      addr_w_ff <= addr_m_ff;
      a_m_ff    <= a_in;
      b_m_ff    <= b_in;
      g_m_ff    <= g_d;
      ova_m_ff  <= ova_in;
      p_w_ff    <= a_m_ff * b_m_ff;
      g_w_ff    <= g_m_ff;
      ova_w_ff  <= ova_m_ff;
      case (op_w_ff)
         OP_TERM: term_ff <= t_w;
         OP_COL:  col_ff[addr_w_ff[ADDR_W-1:IDX_W]] <= r_w;
         OP_ROW:  rowv_ff[addr_w_ff[IDX_W-1:0]] <= v_w;
         default: ;
      endcase
      if (cmd.div_start) begin
         if (term_ff == '0) begin
            f_ff <= (delta > 0) ? DATA_MAX : ((delta < 0) ? DATA_MIN : '0);
         end
         rem_ff  <= '0;
         dv_ff   <= t_abs;
         quo_ff  <= {d_abs[DW-2:0], {FRAC{1'b0}}};
         dcnt_ff <= DCNT_W'(QW);
         neg_ff  <= delta[DW-1] ^ term_ff[DW-1];
      end else if (busy_ff) begin
         rem_ff  <= rem_next;
         quo_ff  <= q_next;
         dcnt_ff <= dcnt_ff - DCNT_W'(1);
         if (dcnt_ff == DCNT_W'(1)) begin
            if (neg_ff) begin
               f_ff <= (q_next > Q_LIM) ? DATA_MIN : -data_type'(q_next[DW-1:0]);
            end else begin
               f_ff <= (q_next > Q_LIM - QW'(1)) ? DATA_MAX : data_type'(q_next[DW-1:0]);
            end
         end
      end
   end

   assign term = term_ff;
   assign res  = res_ff;
   assign ov   = ov_ff;
   assign busy = busy_ff;
endmodule

FILE: rtl/afu_dp.sv
module afu_dp import afu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   input  logic                 spin,
   input  logic [IDX_W-1:0]     row,
   input  logic [IDX_W-1:0]     column,
   input  logic [SLICE_W-1:0]   slice,
   input  logic [IDX_W-1:0]     site,
   input  data_type             entry_value,
   input  logic                 field_bit,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output dp_status_type        status,
   output data_type             out_value,
   output logic                 out_overflow
);
   logic spin_ff, fbit_ff, plus_ff;
   logic [IDX_W-1:0] erow_ff, ecol_ff, site_ff;
   logic [SLICE_W-1:0] slice_ff;
   data_type entry_ff;
   logic [SITES-1:0] frow_ff, frow_in, frdata, fwdata;
   logic fvalid_ff [SLICES];
   logic [SHRINK_W-1:0] shrink_ff;
   logic [GROW_W-1:0] grow_ff;
   data_type out_value_ff;
   logic out_ov_ff;

   data_type d_shrink, d_grow;
   logic [ADDR_W-1:0] addr;
   lane_cmd_type lcmd [2];
   data_type term [2];
   data_type res [2];
   logic ov [2];
   logic busy [2];

   assign d_shrink = DW'($signed(shrink_ff));
   assign d_grow   = {{(DW-GROW_W){1'b0}}, grow_ff};

   always_comb begin
      unique case (cmd.src)
         ADDR_ENTRY: addr = {erow_ff, ecol_ff};
         ADDR_DIAG:  addr = {site_ff, site_ff};
         ADDR_COL:   addr = {cmd.cnt[IDX_W-1:0], site_ff};
         ADDR_ROW:   addr = {site_ff, cmd.cnt[IDX_W-1:0]};
         ADDR_SWEEP: addr = cmd.cnt;
         default:    addr = {erow_ff, ecol_ff};
      endcase
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic en;
      always_comb begin
         unique case (cmd.sel)
            SEL_SPIN: en = (spin_ff == l[0]);
            SEL_BOTH: en = 1'b1;
            SEL_UP:   en = (l == 0);
            default:  en = 1'b0;
         endcase
         lcmd[l].op        = en ? cmd.op : OP_NONE;
         lcmd[l].addr      = addr;
         lcmd[l].wr        = cmd.entry_wr && (spin_ff == l[0]);
         lcmd[l].div_start = cmd.div_start;
         lcmd[l].clear     = cmd.capture;
      end

      afu_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .cmd       (lcmd[l]),
         .wr_data   (entry_ff),
         .delta     (((l == 0) == plus_ff) ? d_shrink : d_grow),
         .peer_term (term[1-l]),
         .diag      (site_ff),
         .term      (term[l]),
         .res       (res[l]),
         .ov        (ov[l]),
         .busy      (busy[l])
      );
   end

   afu_ram #(.WIDTH(SITES), .DEPTH(SLICES)) u_field (
      .clock (clock),
      .we    (cmd.fwr),
      .waddr (slice_ff),
      .wdata (fwdata),
      .raddr (slice_ff),
      .rdata (frdata)
   );

   always_comb begin
      frow_in = fvalid_ff[slice_ff] ? frdata : '0;
      fwdata = frow_ff;
      fwdata[site_ff] = cmd.flip ? ~plus_ff : fbit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shrink_ff <= '0;
         grow_ff   <= '0;
         for (int i = 0; i < SLICES; i++) begin
            fvalid_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SHRINK: shrink_ff <= csr_wdata[SHRINK_W-1:0];
               CSR_GROW:   grow_ff   <= csr_wdata[GROW_W-1:0];
               default: ;
            endcase
         end
         if (cmd.fwr) begin
            fvalid_ff[slice_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         spin_ff  <= spin;
         erow_ff  <= row;
         ecol_ff  <= column;
         slice_ff <= slice;
         site_ff  <= site;
         entry_ff <= entry_value;
         fbit_ff  <= field_bit;
      end
      if (cmd.fcap) begin
         frow_ff <= frow_in;
         plus_ff <= frow_in[site_ff];
      end
      if (cmd.emit) begin
         out_value_ff <= res[0] | res[1];
         out_ov_ff    <= ov[0] | ov[1];
      end
   end

   assign status.busy  = busy[0] | busy[1];
   assign out_value    = out_value_ff;
   assign out_overflow = out_ov_ff;
endmodule

FILE: rtl/afu_ctrl.sv
module afu_ctrl import afu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dp_status_type     status,
   output dp_cmd_type        cmd
);
   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_ENTRY  = 12'b000000000010,
      ST_FREAD  = 12'b000000000100,
      ST_FCAP   = 12'b000000001000,
      ST_FWRITE = 12'b000000010000,
      ST_TERM   = 12'b000000100000,
      ST_RATIO  = 12'b000001000000,
      ST_DSTART = 12'b000010000000,
      ST_DIV    = 12'b000100000000,
      ST_GATHER = 12'b001000000000,
      ST_UPDATE = 12'b010000000000,
      ST_FIN    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in, after_ff, after_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic wait_ff, wait_in;

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      cnt_in   = cnt_ff;
      kind_in  = kind_ff;
      wait_in  = wait_ff;
      cmd      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = (state_ff == ST_IDLE);
      cmd.cnt  = cnt_ff;

      if (wait_ff) begin
         req_ready = 1'b0;
         if (cnt_ff == CNT_W'(DRAIN - 1)) begin
            wait_in  = 1'b0;
            cnt_in   = '0;
            state_in = after_ff;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  kind_in = req_kind;
                  unique case (req_kind)
                     KIND_LOAD, KIND_READ:              state_in = ST_ENTRY;
                     KIND_FLOAD, KIND_QUERY, KIND_FLIP: state_in = ST_FREAD;
                     default:                           state_in = ST_FIN;
                  endcase
               end
            end
            ST_ENTRY: begin
               cmd.src = ADDR_ENTRY;
               cmd.sel = SEL_SPIN;
               if (kind_ff == KIND_LOAD) begin
                  cmd.entry_wr = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  cmd.op = OP_READ;
                  after_in = ST_FIN;
                  wait_in = 1'b1;
                  cnt_in = '0;
               end
            end
            ST_FREAD: state_in = ST_FCAP;
            ST_FCAP: begin
               cmd.fcap = 1'b1;
               state_in = (kind_ff == KIND_FLOAD) ? ST_FWRITE : ST_TERM;
            end
            ST_FWRITE: begin
               cmd.fwr  = 1'b1;
               cmd.flip = (kind_ff == KIND_FLIP);
               state_in = ST_FIN;
            end
            ST_TERM: begin
               cmd.op  = OP_TERM;
               cmd.sel = SEL_BOTH;
               cmd.src = ADDR_DIAG;
               after_in = (kind_ff == KIND_QUERY) ? ST_RATIO : ST_DSTART;
               wait_in = 1'b1;
               cnt_in = '0;
            end
            ST_RATIO: begin
               cmd.op  = OP_RATIO;
               cmd.sel = SEL_UP;
               after_in = ST_FIN;
               wait_in = 1'b1;
               cnt_in = '0;
            end
            ST_DSTART: begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end
            ST_DIV: begin
               if (!status.busy) begin
                  cnt_in = '0;
                  state_in = ST_GATHER;
               end
            end
            ST_GATHER: begin
               cmd.sel = SEL_BOTH;
               cmd.op  = cnt_ff[IDX_W] ? OP_ROW : OP_COL;
               cmd.src = cnt_ff[IDX_W] ? ADDR_ROW : ADDR_COL;
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(2 * SITES - 1)) begin
                  after_in = ST_UPDATE;
                  wait_in = 1'b1;
                  cnt_in = '0;
               end
            end
            ST_UPDATE: begin
               cmd.sel = SEL_BOTH;
               cmd.op  = OP_UPD;
               cmd.src = ADDR_SWEEP;
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(SITES * SITES - 1)) begin
                  after_in = ST_FWRITE;
                  wait_in = 1'b1;
                  cnt_in = '0;
               end
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  cmd.emit = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         after_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         after_ff     <= after_in;
         cnt_ff       <= cnt_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

FILE: rtl/auxiliary_field_flip_update.sv
// An accepted flip runs the 55-step bit-serial factor division, then gathers 32 column and row
// entries and updates all 256 entries, one matrix entry per cycle in each spin lane.
// One item is in work at a time; a finished item waits in the output register.
// Synchronous reset clears the field store through per-slice valid bits and zeroes the
// configuration registers; matrix contents are undefined until loaded.
module auxiliary_field_flip_update import afu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   afu_req_if.sink              req_bus,
   afu_rsp_if.source            rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);
   dp_cmd_type    cmd;
   dp_status_type status;

   afu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   afu_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .spin         (req_bus.spin),
      .row          (req_bus.row),
      .column       (req_bus.column),
      .slice        (req_bus.slice),
      .site         (req_bus.site),
      .entry_value  (req_bus.entry_value),
      .field_bit    (req_bus.field_bit),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .status       (status),
      .out_value    (rsp_bus.result_value),
      .out_overflow (rsp_bus.overflow)
   );

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("item accepted while another is in work");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_bus.ready && !rsp_bus.valid))
      else $error("block not idle after reset");
`endif
endmodule

FILE: tb/sv/testbench.sv
module testbench;
   import afu_pkg::*;

   localparam longint ONE_Q  = 64'sd1 << FRAC;
   localparam longint HALF_Q = 64'sd1 << (FRAC - 1);
   localparam longint VMAX_Q = 64'sd2147483647;
   localparam longint VMIN_Q = -64'sd2147483648;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic               spin;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   column;
      logic [SLICE_W-1:0] slice;
      logic [IDX_W-1:0]   site;
      data_type           entry_value;
      logic               field_bit;
   } flip_item_type;

   typedef struct {
      longint value;
      bit     overflow;
   } outcome_type;

   class flip_scoreboard;
      longint      shrink;
      longint      grow;
      bit          field_store[SLICES*SITES];
      longint      green_up[SITES*SITES];
      longint      green_dn[SITES*SITES];
      outcome_type pending[$];
      int          errors;
      int          matched;
      int          saturations;
      int          kind_count[8];

      function longint clamp(longint x, inout bit ov);
         if (x > VMAX_Q) begin
            ov = 1;
            return VMAX_Q;
         end
         if (x < VMIN_Q) begin
            ov = 1;
            return VMIN_Q;
         end
         return x;
      endfunction

      function longint qmul(longint a, longint b, inout bit ov);
         return clamp((a * b + HALF_Q) >>> FRAC, ov);
      endfunction

      function longint one_plus(longint g, longint d, inout bit ov);
         longint a;
         longint q;
         a = clamp(ONE_Q - g, ov);
         q = qmul(a, d, ov);
         return clamp(ONE_Q + q, ov);
      endfunction

      function void rank_one_update(bit down, int i, longint d, inout bit ov);
         longint m[SITES*SITES];
         longint col[SITES];
         longint rowv[SITES];
         longint den;
         longint f;
         longint p;
         if (down) m = green_dn;
         else m = green_up;
         den = one_plus(m[i*SITES+i], d, ov);
         if (den == 0) begin
            ov = 1;
            f = d > 0 ? VMAX_Q : (d < 0 ? VMIN_Q : 0);
         end else begin
            f = clamp((d * ONE_Q) / den, ov);
         end
         for (int j = 0; j < SITES; j++) begin
            col[j] = qmul(f, m[j*SITES+i], ov);
            rowv[j] = clamp((j == i ? ONE_Q : 0) - m[i*SITES+j], ov);
         end
         for (int j = 0; j < SITES; j++)
            for (int k = 0; k < SITES; k++) begin
               p = qmul(col[j], rowv[k], ov);
               m[j*SITES+k] = clamp(m[j*SITES+k] - p, ov);
            end
         if (down) green_dn = m;
         else green_up = m;
      endfunction

      function void reset_state();
         shrink = 0;
         grow = 0;
         foreach (field_store[n]) field_store[n] = 0;
         foreach (green_up[n]) begin
            green_up[n] = 0;
            green_dn[n] = 0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] value);
         if (index == CSR_SHRINK) shrink = longint'($signed(value[SHRINK_W-1:0]));
         else grow = longint'(value[GROW_W-1:0]);
      endfunction

      function void note_item(flip_item_type it);
         outcome_type o;
         bit          plus;
         longint      d_up;
         longint      d_dn;
         longint      tu;
         longint      td;
         int          fidx;
         int          ii;
         int          eidx;
         o.value = 0;
         o.overflow = 0;
         fidx = int'(it.slice) * SITES + int'(it.site);
         ii = int'(it.site) * SITES + int'(it.site);
         eidx = int'(it.row) * SITES + int'(it.column);
         plus = field_store[fidx];
         d_up = plus ? shrink : grow;
         d_dn = plus ? grow : shrink;
         kind_count[it.kind]++;
         case (it.kind)
            KIND_LOAD: begin
               if (it.spin) green_dn[eidx] = longint'(it.entry_value);
               else green_up[eidx] = longint'(it.entry_value);
            end
            KIND_READ: o.value = it.spin ? green_dn[eidx] : green_up[eidx];
            KIND_FLOAD: field_store[fidx] = it.field_bit;
            KIND_QUERY: begin
               tu = one_plus(green_up[ii], d_up, o.overflow);
               td = one_plus(green_dn[ii], d_dn, o.overflow);
               o.value = qmul(tu, td, o.overflow);
            end
            KIND_FLIP: begin
               rank_one_update(0, int'(it.site), d_up, o.overflow);
               rank_one_update(1, int'(it.site), d_dn, o.overflow);
               field_store[fidx] = !plus;
            end
            default: ;
         endcase
         if (o.overflow) saturations++;
         pending.push_back(o);
      endfunction

      function void check_result(data_type value, logic overflow);
         outcome_type o;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result value %0d overflow %0b", $time, value, overflow);
            errors++;
            return;
         end
         o = pending.pop_front();
         if (value !== data_type'(o.value)) begin
            $display("%0t: result_value expected %0d actual %0d", $time,
                     data_type'(o.value), value);
            errors++;
         end
         if (overflow !== o.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time, o.overflow, overflow);
            errors++;
         end
         matched++;
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   bit                   steady;
   bit                   held;
   int                   stall_left;
   flip_scoreboard       board = new();

   afu_req_if req_if();
   afu_rsp_if rsp_if();

   auxiliary_field_flip_update DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_if.sink),
      .rsp_bus(rsp_if.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial begin
      #(12 * 4000000);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      rsp_if.ready = 1'b0;
      stall_left = 0;
      held = 0;
      forever begin
         int g;
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready)
            board.check_result(rsp_if.result_value, rsp_if.overflow);
         if (!held && board.matched >= 300) begin
            held = 1;
            stall_left = 600;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            g = pick_gap();
            if (g == 0) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               stall_left = g - 1;
            end
         end
      end
   end

   task automatic send_item(flip_item_type it);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_if.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= it.kind;
      req_if.spin <= it.spin;
      req_if.row <= it.row;
      req_if.column <= it.column;
      req_if.slice <= it.slice;
      req_if.site <= it.site;
      req_if.entry_value <= it.entry_value;
      req_if.field_bit <= it.field_bit;
      do @(posedge clock); while (!req_if.ready);
      board.note_item(it);
   endtask

   function automatic flip_item_type blank_item(logic [KIND_W-1:0] kind);
      flip_item_type it;
      it.kind = kind;
      it.spin = 1'($urandom_range(0, 1));
      it.row = IDX_W'($urandom_range(0, SITES - 1));
      it.column = IDX_W'($urandom_range(0, SITES - 1));
      it.slice = SLICE_W'($urandom_range(0, SLICES - 1));
      it.site = IDX_W'($urandom_range(0, SITES - 1));
      it.entry_value = $urandom;
      it.field_bit = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic load_entry(bit spin, int r, int c, data_type v);
      flip_item_type it;
      it = blank_item(KIND_LOAD);
      it.spin = spin;
      it.row = IDX_W'(r);
      it.column = IDX_W'(c);
      it.entry_value = v;
      send_item(it);
   endtask

   task automatic field_item(logic [KIND_W-1:0] kind, int sl, int st, bit b);
      flip_item_type it;
      it = blank_item(kind);
      it.slice = SLICE_W'(sl);
      it.site = IDX_W'(st);
      it.field_bit = b;
      send_item(it);
   endtask

   task automatic read_entry(bit spin, int r, int c);
      flip_item_type it;
      it = blank_item(KIND_READ);
      it.spin = spin;
      it.row = IDX_W'(r);
      it.column = IDX_W'(c);
      send_item(it);
   endtask

   // Matrices near half the identity keep most flips away from saturation.
   function automatic data_type tame_entry(int r, int c);
      int v;
      v = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
      return data_type'((r == c ? int'(ONE_Q) / 2 : 0) + v);
   endfunction

   task automatic fill_matrices();
      for (int s = 0; s < 2; s++)
         for (int r = 0; r < SITES; r++)
            for (int c = 0; c < SITES; c++)
               load_entry(1'(s), r, c, tame_entry(r, c));
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN + 4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(index, value);
   endtask

   function automatic flip_item_type random_item();
      flip_item_type it;
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         it = blank_item(KIND_LOAD);
         if ($urandom_range(0, 3) != 0)
            it.entry_value = tame_entry(int'(it.row), int'(it.column));
      end else if (r < 38) it = blank_item(KIND_READ);
      else if (r < 50) it = blank_item(KIND_FLOAD);
      else if (r < 78) it = blank_item(KIND_QUERY);
      else if (r < 95) it = blank_item(KIND_FLIP);
      else it = blank_item(KIND_W'(KIND_FLIP + $urandom_range(1, 3)));
      return it;
   endfunction

   initial begin
      longint shrink_set[4];
      longint grow_set[4];
      board.reset_state();
      reset = 1'b1;
      steady = 0;
      csr_we = 1'b0;
      csr_index = CSR_SHRINK;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.kind = KIND_LOAD;
      req_if.spin = 1'b0;
      req_if.row = '0;
      req_if.column = '0;
      req_if.slice = '0;
      req_if.site = '0;
      req_if.entry_value = '0;
      req_if.field_bit = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      shrink_set[0] = 0;
      grow_set[0] = 0;
      shrink_set[1] = -ONE_Q;
      grow_set[1] = 64'h7FFFFFFF;
      shrink_set[2] = -longint'($urandom_range(1 << 20, 1 << 24));
      grow_set[2] = longint'($urandom_range(1 << 20, 1 << 26));
      shrink_set[3] = -longint'($urandom_range(0, 1 << 24));
      grow_set[3] = longint'($urandom_range(0, 32'h7FFFFFFF));

      for (int ph = 0; ph < 4; ph++) begin
         steady = (ph == 2);
         write_csr(CSR_SHRINK, CSR_W'(shrink_set[ph]));
         write_csr(CSR_GROW, CSR_W'(grow_set[ph]));
         csr_we <= 1'b0;
         if (ph == 0) begin
            fill_matrices();
            load_entry(0, 15, 15, DATA_MAX);
            read_entry(0, 15, 15);
            load_entry(1, 0, 0, DATA_MIN);
            read_entry(1, 0, 0);
            field_item(KIND_QUERY, 0, 0, 0);
            field_item(KIND_FLOAD, SLICES - 1, SITES - 1, 1);
            field_item(KIND_QUERY, SLICES - 1, SITES - 1, 0);
            field_item(KIND_FLIP, SLICES - 1, SITES - 1, 0);
            field_item(KIND_QUERY, SLICES - 1, SITES - 1, 0);
            field_item(KIND_FLIP, 0, 0, 0);
            read_entry(0, 0, 0);
            read_entry(1, 15, 15);
            field_item(KIND_W'(KIND_FLIP + 3), 7, 7, 1);
            field_item(KIND_W'(KIND_FLIP + 1), 0, 0, 0);
         end
         if (ph == 1) begin
            // With the shrink factor at minus one, a zero diagonal zeroes the denominator.
            load_entry(0, 3, 3, '0);
            field_item(KIND_FLOAD, 5, 3, 1);
            field_item(KIND_QUERY, 5, 3, 0);
            field_item(KIND_FLIP, 5, 3, 0);
            read_entry(0, 3, 3);
            read_entry(1, 0, 3);
            field_item(KIND_FLIP, 9, 12, 0);
         end
         for (int n = 0; n < 55; n++) send_item(random_item());
         drain();
      end

      $display("Covered %0d loads, %0d reads, %0d field loads, %0d queries, %0d flips,",
               board.kind_count[KIND_LOAD], board.kind_count[KIND_READ],
               board.kind_count[KIND_FLOAD], board.kind_count[KIND_QUERY],
               board.kind_count[KIND_FLIP]);
      $display("%0d results checked across 4 settings, %0d with saturation.",
               board.matched, board.saturations);
      if (board.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
